// ===== rtl/skt_pkg.sv =====
package skt_pkg;

  // Field widths of one command word and one result word
  localparam int unsigned KeyW    = 16;
  localparam int unsigned HandleW = 32;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CountW  = 7;

  // Command codes; code 3 is unused and leaves the table alone
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } entry_t;

  // Per-cycle action of the cell chain
  typedef enum logic [1:0] {
    OP_HOLD,    // every cell keeps its entry
    OP_ROTATE,  // pop the head, push it back at the tail
    OP_DROP,    // pop the head and discard it
    OP_APPEND   // write the new entry just past the tail
  } cell_op_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

// ===== rtl/skt_cell.sv =====
module skt_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic               clk_i,
  input  skt_pkg::cell_op_e  op_i,
  input  logic [CntW-1:0]    fill_i,
  input  skt_pkg::entry_t    head_i,
  input  skt_pkg::entry_t    next_i,
  input  skt_pkg::entry_t    new_i,
  output skt_pkg::entry_t    entry_o
);

  skt_pkg::entry_t entry_q, entry_d;

  // Local select: keep, take from the right neighbor, take the head or the new entry
  always_comb begin
    entry_d = entry_q;
    unique case (op_i)
      skt_pkg::OP_HOLD: begin
        entry_d = entry_q;
      end
      skt_pkg::OP_APPEND: begin
        if (fill_i == CntW'(Idx)) begin
          entry_d = new_i;
        end
      end
      skt_pkg::OP_ROTATE: begin
        // tail cell receives the popped head, the rest move one toward the head
        entry_d = (fill_i == CntW'(Idx + 1)) ? head_i : next_i;
      end
      skt_pkg::OP_DROP: begin
        entry_d = next_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/sorted_key_table_core.sv =====
// Entries sit in a chain of cells used as a circular queue; a command rotates it once.
// Lookup, remove: each entry is rotated or dropped once; done strobe comes with idle.
// Insert: as lookup, plus one append step to write the new word at its place.
// Full insert, unused code or empty table: no pass; an empty-table insert only appends.
// Reset clears the entry count and the sequencer; stored entries are not cleared.
// Results are shown for exactly one cycle on done_o; the receiver cannot stall.
module sorted_key_table_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skt_pkg::CmdW-1:0]     cmd_i,
  input  logic [skt_pkg::KeyW-1:0]     key_i,
  input  logic [skt_pkg::HandleW-1:0]  handle_in_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic                         found_o,
  output logic [skt_pkg::HandleW-1:0]  handle_out_o,
  output logic [skt_pkg::CountW-1:0]   entry_count_o,
  output logic [skt_pkg::CountW-1:0]   removed_count_o,
  output logic                         status_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  skt_pkg::state_e                state_q, state_d;
  logic [skt_pkg::CmdW-1:0]       cmd_q, cmd_d;
  skt_pkg::entry_t                new_q, new_d;
  logic [CntW-1:0]                fill_q, fill_d;
  logic [CntW-1:0]                rem_q, rem_d;
  logic [CntW-1:0]                removed_q, removed_d;
  logic                           found_q, found_d;
  logic [skt_pkg::HandleW-1:0]    hout_q, hout_d;
  logic                           status_q, status_d;
  logic                           placed_q, placed_d;
  logic                           done_q, done_d;
  logic                           full;
  skt_pkg::cell_op_e              cell_op;
  skt_pkg::entry_t                cell_out [DEPTH];
  skt_pkg::entry_t                head;

  assign head = cell_out[0];
  assign full = (fill_q == CntW'(DEPTH));

  // Cell chain: each cell hands its entry to the left neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    skt_pkg::entry_t next_entry;
    if (g == DEPTH - 1) begin : g_last
      assign next_entry = head;
    end else begin : g_mid
      assign next_entry = cell_out[g+1];
    end
    skt_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .fill_i  (fill_q),
      .head_i  (head),
      .next_i  (next_entry),
      .new_i   (new_q),
      .entry_o (cell_out[g])
    );
  end

  // Sequencer: next state, chain action and result bookkeeping
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    new_d     = new_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    removed_d = removed_q;
    found_d   = found_q;
    hout_d    = hout_q;
    status_d  = status_q;
    placed_d  = placed_q;
    done_d    = 1'b0;
    cell_op   = skt_pkg::OP_HOLD;
    unique case (state_q)
      skt_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_d        = cmd_i;
          new_d.key    = key_i;
          new_d.handle = handle_in_i;
          found_d      = 1'b0;
          hout_d       = '0;
          removed_d    = '0;
          status_d     = (cmd_i == skt_pkg::CMD_INSERT) && full;
          placed_d     = (cmd_i != skt_pkg::CMD_INSERT) || full;
          // one pass over the stored entries, none for a dropped insert or unused code
          if ((cmd_i == skt_pkg::CMD_LOOKUP) || (cmd_i == skt_pkg::CMD_REMOVE) ||
              ((cmd_i == skt_pkg::CMD_INSERT) && !full)) begin
            rem_d = fill_q;
          end else begin
            rem_d = '0;
          end
          state_d = skt_pkg::ST_SCAN;
        end
      end
      skt_pkg::ST_SCAN: begin
        if (!placed_q && ((rem_q == '0) || (head.key >= new_q.key))) begin
          // new entry goes before the first entry with key >= its own
          cell_op  = skt_pkg::OP_APPEND;
          fill_d   = fill_q + CntW'(1);
          placed_d = 1'b1;
        end else if (rem_q == '0) begin
          done_d  = 1'b1;
          state_d = skt_pkg::ST_IDLE;
        end else begin
          rem_d = rem_q - CntW'(1);
          case (cmd_q)
            skt_pkg::CMD_LOOKUP: begin
              cell_op = skt_pkg::OP_ROTATE;
              if (!found_q && (head.key == new_q.key)) begin
                found_d = 1'b1;
                hout_d  = head.handle;
              end
            end
            skt_pkg::CMD_REMOVE: begin
              if (head.key == new_q.key) begin
                cell_op   = skt_pkg::OP_DROP;
                fill_d    = fill_q - CntW'(1);
                removed_d = removed_q + CntW'(1);
              end else begin
                cell_op = skt_pkg::OP_ROTATE;
              end
            end
            default: begin
              cell_op = skt_pkg::OP_ROTATE;
            end
          endcase
        end
      end
      default: begin
        state_d = skt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::ST_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  // Command and result registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    new_q     <= new_d;
    rem_q     <= rem_d;
    removed_q <= removed_d;
    found_q   <= found_d;
    hout_q    <= hout_d;
    status_q  <= status_d;
    placed_q  <= placed_d;
  end

  assign busy_o          = (state_q != skt_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign found_o         = found_q;
  assign handle_out_o    = hout_q;
  assign entry_count_o   = skt_pkg::CountW'(fill_q);
  assign removed_count_o = skt_pkg::CountW'(removed_q);
  assign status_o        = status_q;

  // Entry count never passes the table size
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH))
    else $error("entry count above table size");

  // Result strobe only comes with the sequencer back at idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == skt_pkg::ST_IDLE))
    else $error("result strobe while busy");

  // Entry count only changes during a pass
  a_fill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skt_pkg::ST_IDLE) |=> $stable(fill_q))
    else $error("entry count changed while idle");

  // Insert into a full table reports rejection with status set on the done strobe
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == skt_pkg::CMD_INSERT) && full)
      |-> ##2 (done_o && status_o))
    else $error("full insert not rejected");

  // Only remove reports deleted entries
  a_removed_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (removed_q != '0)) |-> (cmd_q == skt_pkg::CMD_REMOVE))
    else $error("removed count on a non-remove word");

endmodule
